@@ hdl/bfra_pkg.sv @@
// ----------------------------------------------------------------------------
// bfra_pkg
// Types, constants and helper functions shared by the allocator modules.
// ----------------------------------------------------------------------------
package bfra_pkg;

    localparam int MAX_TYPES = 16;
    localparam int MAX_UNITS = 64;

    // index counter holds 0..MAX_TYPES, entry address within a class is narrower
    localparam int IDX_W = $clog2(MAX_TYPES + 1);
    localparam int POS_W = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
    localparam int TAB_DEPTH = 2 * (2 ** POS_W);

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_FIND = 3'd1;
    localparam logic [2:0] OP_TAKE = 3'd2;
    localparam logic [2:0] OP_GIVE = 3'd3;
    localparam logic [2:0] OP_READ = 3'd4;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_NOFIT  = 3'd1;
    localparam logic [2:0] ST_ABSENT = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_EMPTY  = 3'd4;

    typedef logic [MAX_UNITS-1:0] t_map;

    typedef struct packed {
        logic [7:0]  key;
        logic [31:0] mem;
        logic [31:0] pwr;
        logic [31:0] rate;
        t_map        map;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_RD, S_EV, S_SH_RD, S_SH_WR, S_INSERT, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        RK_PLAIN, RK_FIT, RK_TAKE, RK_ATTR
    } t_rkind;

    typedef struct packed {
        logic       in_ready;
        logic       idx_clr;
        logic       idx_inc;
        logic       idx_dec;
        logic       idx_to_n;
        logic       pos_save;
        logic       rd_scan;
        logic       rd_shift;
        logic       wr_shift;
        logic       wr_take;
        logic       wr_give;
        logic       wr_new;
        logic       n_inc;
        logic       nz_inc;
        logic       nz_dec;
        logic       res_load;
        t_rkind     res_kind;
        logic [2:0] res_status;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic       in_valid;
        logic [2:0] op;
        logic       cnt_zero;
        logic       full;
        logic       at_n;
        logic       at_pos;
        logic       key_match;
        logic       fit_ok;
        logic       ins_here;
        logic       map_zero;
        logic       map_one;
        logic       unit_ok;
        logic       out_free;
    } t_stat;

    function automatic t_map unit_mask(input logic [6:0] cnt);
        t_map m;
        for (int i = 0; i < MAX_UNITS; i++) begin
            m[i] = (7'(i) < cnt);
        end
        return m;
    endfunction

    function automatic logic [5:0] top_unit(input t_map m);
        logic [5:0] r;
        r = 6'd0;
        for (int i = 0; i < MAX_UNITS; i++) begin
            if (m[i]) r = 6'(i);
        end
        return r;
    endfunction

endpackage

@@ hdl/bfra_in_if.sv @@
// ----------------------------------------------------------------------------
// bfra_in_if
// Request channel: valid/ready with the request fields.
// ----------------------------------------------------------------------------
interface bfra_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic        resource_class;
    logic [7:0]  type_key;
    logic [5:0]  unit_index;
    logic [6:0]  unit_count;
    logic [31:0] ops_rate;
    logic [31:0] memory_size;
    logic [31:0] power_draw;
    logic [31:0] memory_needed;

    modport source (output valid, opcode, resource_class, type_key, unit_index,
                    unit_count, ops_rate, memory_size, power_draw, memory_needed,
                    input ready);
    modport sink   (input valid, opcode, resource_class, type_key, unit_index,
                    unit_count, ops_rate, memory_size, power_draw, memory_needed,
                    output ready);
endinterface

@@ hdl/bfra_out_if.sv @@
// ----------------------------------------------------------------------------
// bfra_out_if
// Result channel: valid/ready with the result fields.
// ----------------------------------------------------------------------------
interface bfra_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  found_key;
    logic [5:0]  found_unit;
    logic [31:0] memory_out;
    logic [31:0] power_out;
    logic [31:0] rate_out;
    logic        switch_pool_empty;
    logic        cpu_pool_empty;

    modport source (output valid, status, found_key, found_unit, memory_out,
                    power_out, rate_out, switch_pool_empty, cpu_pool_empty,
                    input ready);
    modport sink   (input valid, status, found_key, found_unit, memory_out,
                    power_out, rate_out, switch_pool_empty, cpu_pool_empty,
                    output ready);
endinterface

@@ hdl/bfra_ctrl.sv @@
// ----------------------------------------------------------------------------
// bfra_ctrl
// Sequencer: scans the sorted entries, shifts for insertion, issues results.
// ----------------------------------------------------------------------------
module bfra_ctrl
    import bfra_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_stat.in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (i_stat.op)
                    OP_ADD: begin
                        if (i_stat.cnt_zero || i_stat.full) n_state = S_DONE;
                        else                                n_state = S_RD;
                    end
                    OP_FIND, OP_TAKE, OP_GIVE, OP_READ: n_state = S_RD;
                    default: n_state = S_DONE;
                endcase
            end
            S_RD: begin
                if (i_stat.at_n) n_state = (i_stat.op == OP_ADD) ? S_SH_RD : S_DONE;
                else             n_state = S_EV;
            end
            S_EV: begin
                case (i_stat.op)
                    OP_ADD:  n_state = i_stat.ins_here ? S_SH_RD : S_RD;
                    OP_FIND: n_state = i_stat.fit_ok ? S_DONE : S_RD;
                    default: n_state = i_stat.key_match ? S_DONE : S_RD;
                endcase
            end
            S_SH_RD: n_state = i_stat.at_pos ? S_INSERT : S_SH_WR;
            S_SH_WR: n_state = S_SH_RD;
            S_INSERT: n_state = S_DONE;
            S_DONE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.res_kind   = RK_PLAIN;
        o_cmd.res_status = ST_OK;
        case (r_state)
            S_IDLE: o_cmd.in_ready = 1'b1;
            S_DECODE: begin
                case (i_stat.op)
                    OP_ADD: begin
                        if (i_stat.cnt_zero) begin
                            o_cmd.res_load = 1'b1;
                        end else if (i_stat.full) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_FULL;
                        end else begin
                            o_cmd.idx_clr = 1'b1;
                        end
                    end
                    OP_FIND, OP_TAKE, OP_GIVE, OP_READ: o_cmd.idx_clr = 1'b1;
                    default: o_cmd.res_load = 1'b1;
                endcase
            end
            S_RD: begin
                if (i_stat.at_n) begin
                    case (i_stat.op)
                        OP_ADD: o_cmd.pos_save = 1'b1;
                        OP_FIND: begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_NOFIT;
                        end
                        default: begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_ABSENT;
                        end
                    endcase
                end else begin
                    o_cmd.rd_scan = 1'b1;
                end
            end
            S_EV: begin
                case (i_stat.op)
                    OP_ADD: begin
                        if (i_stat.ins_here) begin
                            o_cmd.pos_save = 1'b1;
                            o_cmd.idx_to_n = 1'b1;
                        end else begin
                            o_cmd.idx_inc = 1'b1;
                        end
                    end
                    OP_FIND: begin
                        if (i_stat.fit_ok) begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_kind = RK_FIT;
                        end else begin
                            o_cmd.idx_inc = 1'b1;
                        end
                    end
                    OP_TAKE: begin
                        if (!i_stat.key_match) begin
                            o_cmd.idx_inc = 1'b1;
                        end else if (i_stat.map_zero) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_EMPTY;
                        end else begin
                            o_cmd.wr_take  = 1'b1;
                            o_cmd.nz_dec   = i_stat.map_one;
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_kind = RK_TAKE;
                        end
                    end
                    OP_GIVE: begin
                        if (i_stat.key_match) begin
                            o_cmd.wr_give  = i_stat.unit_ok;
                            o_cmd.nz_inc   = i_stat.unit_ok && i_stat.map_zero;
                            o_cmd.res_load = 1'b1;
                        end else begin
                            o_cmd.idx_inc = 1'b1;
                        end
                    end
                    OP_READ: begin
                        if (i_stat.key_match) begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_kind = RK_ATTR;
                        end else begin
                            o_cmd.idx_inc = 1'b1;
                        end
                    end
                    default: o_cmd.idx_inc = 1'b1;
                endcase
            end
            S_SH_RD: o_cmd.rd_shift = !i_stat.at_pos;
            S_SH_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_dec  = 1'b1;
            end
            S_INSERT: begin
                o_cmd.wr_new   = 1'b1;
                o_cmd.n_inc    = 1'b1;
                o_cmd.nz_inc   = 1'b1;
                o_cmd.res_load = 1'b1;
            end
            S_DONE: o_cmd.out_load = i_stat.out_free;
            default: ;
        endcase
    end

endmodule

@@ hdl/bfra_dp.sv @@
// ----------------------------------------------------------------------------
// bfra_dp
// Datapath: type table memory, request and result registers, class counters.
// ----------------------------------------------------------------------------
module bfra_dp
    import bfra_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    bfra_in_if.sink        i_req,
    bfra_out_if.source     o_rsp,
    input  t_cmd           i_cmd,
    output t_stat          o_stat
);

    // latched request
    logic [2:0]  r_op;
    logic        r_cls;
    logic [7:0]  r_key;
    logic [5:0]  r_unit;
    logic [6:0]  r_cnt;
    logic [31:0] r_rate, r_mem, r_pwr, r_need;

    logic [IDX_W-1:0] r_n [2];
    logic [IDX_W-1:0] r_nz [2];   // entries with at least one free unit
    logic [IDX_W-1:0] r_idx, r_pos;

    t_entry r_tab [TAB_DEPTH];
    t_entry r_rd;

    logic [2:0]  r_res_status;
    logic [7:0]  r_res_key;
    logic [5:0]  r_res_unit;
    logic [31:0] r_res_mem, r_res_pwr, r_res_rate;

    logic        r_ov;
    logic [2:0]  r_o_status;
    logic [7:0]  r_o_key;
    logic [5:0]  r_o_unit;
    logic [31:0] r_o_mem, r_o_pwr, r_o_rate;
    logic        r_o_sw_empty, r_o_cpu_empty;

    logic [IDX_W-1:0]     n_cur;
    logic [IDX_W-1:0]     idx_m1;
    logic [POS_W:0]       rd_addr, wr_addr;
    logic                 rd_en, wr_en;
    t_entry               wr_data;
    logic [5:0]           top;
    t_map                 take_map, give_map;
    logic                 accept;

    assign accept = i_cmd.in_ready && i_req.valid;
    assign i_req.ready = i_cmd.in_ready;

    assign n_cur  = r_n[r_cls];
    assign idx_m1 = r_idx - 1'b1;
    assign top    = top_unit(r_rd.map);
    assign take_map = r_rd.map & ~(t_map'(1) << top);
    assign give_map = r_rd.map | (t_map'(1) << r_unit);

    always_comb begin
        rd_en   = i_cmd.rd_scan || i_cmd.rd_shift;
        rd_addr = i_cmd.rd_shift ? {r_cls, idx_m1[POS_W-1:0]} : {r_cls, r_idx[POS_W-1:0]};
        wr_en   = i_cmd.wr_shift || i_cmd.wr_take || i_cmd.wr_give || i_cmd.wr_new;
        wr_addr = {r_cls, r_idx[POS_W-1:0]};
        wr_data = r_rd;
        if (i_cmd.wr_take) wr_data.map = take_map;
        if (i_cmd.wr_give) wr_data.map = give_map;
        if (i_cmd.wr_new) begin
            wr_data.key  = r_key;
            wr_data.mem  = r_mem;
            wr_data.pwr  = r_pwr;
            wr_data.rate = r_rate;
            wr_data.map  = unit_mask(r_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_tab[wr_addr] <= wr_data;
        if (rd_en) r_rd <= r_tab[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_req.opcode;
            r_cls  <= i_req.resource_class;
            r_key  <= i_req.type_key;
            r_unit <= i_req.unit_index;
            r_cnt  <= i_req.unit_count;
            r_rate <= i_req.ops_rate;
            r_mem  <= i_req.memory_size;
            r_pwr  <= i_req.power_draw;
            r_need <= i_req.memory_needed;
        end
        if (i_cmd.idx_clr)       r_idx <= '0;
        else if (i_cmd.idx_inc)  r_idx <= r_idx + 1'b1;
        else if (i_cmd.idx_dec)  r_idx <= idx_m1;
        else if (i_cmd.idx_to_n) r_idx <= n_cur;
        if (i_cmd.pos_save) r_pos <= r_idx;
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            r_res_key    <= 8'd0;
            r_res_unit   <= 6'd0;
            r_res_mem    <= 32'd0;
            r_res_pwr    <= 32'd0;
            r_res_rate   <= 32'd0;
            case (i_cmd.res_kind)
                RK_FIT: begin
                    r_res_key  <= r_rd.key;
                    r_res_unit <= top;
                end
                RK_TAKE: begin
                    r_res_key  <= r_key;
                    r_res_unit <= top;
                end
                RK_ATTR: begin
                    r_res_mem  <= r_rd.mem;
                    r_res_pwr  <= r_rd.pwr;
                    r_res_rate <= r_rd.rate;
                end
                default: ;
            endcase
        end
        if (i_cmd.out_load) begin
            r_o_status    <= r_res_status;
            r_o_key       <= r_res_key;
            r_o_unit      <= r_res_unit;
            r_o_mem       <= r_res_mem;
            r_o_pwr       <= r_res_pwr;
            r_o_rate      <= r_res_rate;
            r_o_sw_empty  <= (r_nz[0] == '0);
            r_o_cpu_empty <= (r_nz[1] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n[0]  <= '0;
            r_n[1]  <= '0;
            r_nz[0] <= '0;
            r_nz[1] <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cmd.n_inc)  r_n[r_cls]  <= r_n[r_cls] + 1'b1;
            if (i_cmd.nz_inc) r_nz[r_cls] <= r_nz[r_cls] + 1'b1;
            else if (i_cmd.nz_dec) r_nz[r_cls] <= r_nz[r_cls] - 1'b1;
            if (i_cmd.out_load)   r_ov <= 1'b1;
            else if (o_rsp.ready) r_ov <= 1'b0;
        end
    end

    always_comb begin
        o_stat.in_valid  = i_req.valid;
        o_stat.op        = r_op;
        o_stat.cnt_zero  = (r_cnt == 7'd0);
        o_stat.full      = ({1'b0, n_cur} >= (IDX_W + 1)'(MAX_TYPES));
        o_stat.at_n      = (r_idx == n_cur);
        o_stat.at_pos    = (r_idx == r_pos);
        o_stat.key_match = (r_rd.key == r_key);
        o_stat.fit_ok    = (r_rd.map != '0) && (r_rd.mem >= r_need);
        o_stat.ins_here  = (r_rd.mem > r_mem) || ((r_rd.mem == r_mem) && (r_rd.rate < r_rate));
        o_stat.map_zero  = (r_rd.map == '0);
        o_stat.map_one   = (take_map == '0);
        o_stat.unit_ok   = ({1'b0, r_unit} < 7'(MAX_UNITS));
        o_stat.out_free  = !r_ov || o_rsp.ready;
    end

    assign o_rsp.valid             = r_ov;
    assign o_rsp.status            = r_o_status;
    assign o_rsp.found_key         = r_o_key;
    assign o_rsp.found_unit        = r_o_unit;
    assign o_rsp.memory_out        = r_o_mem;
    assign o_rsp.power_out         = r_o_pwr;
    assign o_rsp.rate_out          = r_o_rate;
    assign o_rsp.switch_pool_empty = r_o_sw_empty;
    assign o_rsp.cpu_pool_empty    = r_o_cpu_empty;

endmodule

@@ hdl/best_fit_resource_allocator.sv @@
// ----------------------------------------------------------------------------
// best_fit_resource_allocator
// Two-class sorted resource type table with best-fit lookup and unit tracking.
//
//   channel  | dir | handshake       | beat
//   i_req    | in  | valid/ready     | one request (opcode and fields)
//   o_rsp    | out | valid/ready     | one result per request
//
// a request reads the entries in turn from the table memory, which has a
// registered read; an insertion then shifts the entries from the insertion
// point up by one to make room, with at most 16 entries per class
// reset clears the entry counts; no clearing pass over the table
// one request at a time; a finished result waits in the output register
// ----------------------------------------------------------------------------
module best_fit_resource_allocator
    import bfra_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    bfra_in_if.sink    i_req,
    bfra_out_if.source o_rsp
);

    t_cmd  cmd;
    t_stat stat;

    bfra_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    bfra_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );

endmodule
